>>> rtl/core/rmgr_pkg.sv
// ----------------------------------------------------------------------------
// rmgr_pkg: shared constants for the rhythm mask guard rails
// Field widths, register indexes, zone and style codes, reset values.
// ----------------------------------------------------------------------------
package rmgr_pkg;

    localparam int MASK_W = 64;
    localparam int LIM_W  = 7;
    localparam int CNT_W  = 5;

    localparam int MAX_STEPS_DEF     = 64;
    localparam int GAP_FIX_LIMIT_DEF = 8;
    localparam int RUN_FIX_LIMIT_DEF = 16;

    localparam logic [2:0] REG_GAP_GROOVE = 3'd0;
    localparam logic [2:0] REG_GAP_BUILD  = 3'd1;
    localparam logic [2:0] REG_GAP_PEAK   = 3'd2;
    localparam logic [2:0] REG_RUN_NORMAL = 3'd3;
    localparam logic [2:0] REG_RUN_PEAK   = 3'd4;
    localparam logic [2:0] REG_BACKBEAT   = 3'd5;

    localparam logic [1:0] ZONE_MINIMAL = 2'd0;
    localparam logic [1:0] ZONE_GROOVE  = 2'd1;
    localparam logic [1:0] ZONE_BUILD   = 2'd2;
    localparam logic [1:0] ZONE_PEAK    = 2'd3;
    localparam logic [1:0] STYLE_TECHNO = 2'd0;
    localparam logic [1:0] STYLE_TRIBAL = 2'd1;
    localparam logic [1:0] STYLE_IDM    = 2'd2;
    localparam logic [1:0] STYLE_OTHER  = 2'd3;

    localparam logic [LIM_W-1:0] GAP_MINIMAL = 7'd32;
    localparam logic [LIM_W-1:0] RUN_MINIMAL = 7'd2;
    localparam logic [LIM_W-1:0] BACKBEAT_MIN_STEPS = 7'd16;
    localparam int BACKBEAT_STEP = 8;

    localparam logic [LIM_W-1:0]  GAP_GROOVE_RST = 7'd8;
    localparam logic [LIM_W-1:0]  GAP_BUILD_RST  = 7'd6;
    localparam logic [LIM_W-1:0]  GAP_PEAK_RST   = 7'd4;
    localparam logic [LIM_W-1:0]  RUN_NORMAL_RST = 7'd4;
    localparam logic [LIM_W-1:0]  RUN_PEAK_RST   = 7'd6;
    localparam logic [MASK_W-1:0] BACKBEAT_RST   = 64'h0000_0000_0100_0100;

endpackage

>>> rtl/core/rhythm_mask_guard_rails.sv
// ----------------------------------------------------------------------------
// rhythm_mask_guard_rails: rule-based repair of anchor and shimmer masks
// Downbeat, gap fill, run trim and techno backbeat, scanned one step a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one pattern request: anchor and
//   shimmer masks, energy zone, style and length. Output channel
//   (out_valid/out_stall) returns the repaired masks and the fix count.
//   The masks sit in circular shift registers that rotate one step per
//   cycle; a single narrow scanner (counters and a few flags) looks at bit 0.
//   Sequence: the accept, then up to 8 gap scans over two laps of the
//   pattern (a scan that breaks early adds a realign), then run passes:
//   a longest-run sweep over two laps, and per trim a realign, a linear
//   search and a drop; at most 16 trims. A final realign, the backbeat
//   check and the handover close it. One request is in flight at a time;
//   the next request is taken once the result has moved into the output
//   register, so a result waiting under out_stall does not hold back the
//   next scan, only its delivery. Reset clears state_reg and out_valid and
//   loads the configuration registers with the reset values from rmgr_pkg.
//   Configuration writes (cfg_we/cfg_index/cfg_data) are taken any cycle but
//   are only meant while the block is idle.
// ----------------------------------------------------------------------------
module rhythm_mask_guard_rails #(
    parameter int MAX_STEPS     = rmgr_pkg::MAX_STEPS_DEF,
    parameter int GAP_FIX_LIMIT = rmgr_pkg::GAP_FIX_LIMIT_DEF,
    parameter int RUN_FIX_LIMIT = rmgr_pkg::RUN_FIX_LIMIT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [rmgr_pkg::MASK_W-1:0]  cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [rmgr_pkg::MASK_W-1:0]  anchor_in,
    input  logic [rmgr_pkg::MASK_W-1:0]  shimmer_in,
    input  logic [1:0]                   energy_zone,
    input  logic [1:0]                   style,
    input  logic [rmgr_pkg::LIM_W-1:0]   steps,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [rmgr_pkg::MASK_W-1:0]  anchor_out,
    output logic [rmgr_pkg::MASK_W-1:0]  shimmer_out,
    output logic [rmgr_pkg::CNT_W-1:0]   fix_count
);

    localparam int W  = rmgr_pkg::MASK_W;
    localparam int LW = rmgr_pkg::LIM_W;
    localparam int GW = $clog2(GAP_FIX_LIMIT + 1);
    localparam int RW = $clog2(RUN_FIX_LIMIT + 1);
    localparam logic [LW-1:0] MAXS = LW'(MAX_STEPS);

    typedef enum logic [3:0] {
        S_IDLE, S_GAP, S_GAP_ADD, S_RUN_LONG, S_RUN_FIND, S_RUN_ALIGN,
        S_BEAT, S_DONE
    } state_t;

    // configuration registers
    logic [LW-1:0] gap_groove_reg, gap_build_reg, gap_peak_reg;
    logic [LW-1:0] run_normal_reg, run_peak_reg;
    logic [W-1:0]  backbeat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_groove_reg <= rmgr_pkg::GAP_GROOVE_RST;
            gap_build_reg  <= rmgr_pkg::GAP_BUILD_RST;
            gap_peak_reg   <= rmgr_pkg::GAP_PEAK_RST;
            run_normal_reg <= rmgr_pkg::RUN_NORMAL_RST;
            run_peak_reg   <= rmgr_pkg::RUN_PEAK_RST;
            backbeat_reg   <= rmgr_pkg::BACKBEAT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rmgr_pkg::REG_GAP_GROOVE: gap_groove_reg <= cfg_data[LW-1:0];
                rmgr_pkg::REG_GAP_BUILD:  gap_build_reg  <= cfg_data[LW-1:0];
                rmgr_pkg::REG_GAP_PEAK:   gap_peak_reg   <= cfg_data[LW-1:0];
                rmgr_pkg::REG_RUN_NORMAL: run_normal_reg <= cfg_data[LW-1:0];
                rmgr_pkg::REG_RUN_PEAK:   run_peak_reg   <= cfg_data[LW-1:0];
                rmgr_pkg::REG_BACKBEAT:   backbeat_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // working state
    state_t        state_reg;
    logic [W-1:0]  a_reg, sh_reg;      // rotating masks, bit 0 is step pos_reg
    logic [W-1:0]  sh_full_reg;        // unrotated shimmer copy for the backbeat test
    logic [LW-1:0] len_reg, steps_reg, gap_reg, run_reg;
    logic [1:0]    zone_reg, style_reg;
    logic [LW-1:0] pos_reg;            // current step index
    logic [LW:0]   i_reg;              // scan cycle counter
    logic [LW:0]   glen_reg;           // gap length / run length
    logic [LW-1:0] start_reg;          // gap start step
    logic          in_gap_reg, hit_reg, any_a_reg;
    logic [LW-1:0] mid_reg;            // lowest midpoint seen
    logic [LW:0]   best_reg;
    logic          found_reg;
    logic [LW-1:0] at_reg;
    logic [GW-1:0] gfix_reg;
    logic [RW-1:0] rfix_reg;
    logic [rmgr_pkg::CNT_W-1:0] fix_reg;
    logic [rmgr_pkg::CNT_W-1:0] fix_inc;

    // hold the count at its top value
    assign fix_inc = (&fix_reg) ? fix_reg : fix_reg + 5'd1;

    // the masks rotate right by one within len steps
    function automatic logic [W-1:0] rot1(input logic [W-1:0] m, input logic [LW-1:0] n);
        logic [W-1:0] r;
        r = m;
        for (int k = 0; k < W; k++)
        begin
            if (7'(k + 1) < n)
                r[k] = m[k+1];
            else if (7'(k + 1) == n)
                r[k] = m[0];
        end
        return r;
    endfunction

    logic [LW:0]   len2;
    logic [LW-1:0] mid_pos;
    logic          pos_last;
    logic [LW:0]   glen_inc;
    logic [LW:0]   half;
    logic [LW+1:0] mid_sum;
    logic          downbeat;

    assign len2     = {len_reg, 1'b0};
    assign pos_last = (pos_reg + 7'd1 == len_reg);
    assign glen_inc = glen_reg + 8'd1;
    assign half     = glen_reg >> 1;
    assign mid_sum  = {2'b0, start_reg} + {1'b0, half};
    // start < len and half < len, so one subtract wraps the midpoint
    assign mid_pos  = (mid_sum >= {2'b0, len_reg}) ? LW'(mid_sum - {2'b0, len_reg})
                                                   : mid_sum[LW-1:0];
    assign downbeat = (energy_zone != rmgr_pkg::ZONE_MINIMAL) && !anchor_in[0];

    logic sonly;
    assign sonly = sh_reg[0] & ~a_reg[0];

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall && state_reg != S_DONE)
                out_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        // downbeat folded into the load
                        a_reg       <= anchor_in | {{(W-1){1'b0}}, downbeat};
                        fix_reg     <= {4'b0, downbeat};
                        sh_reg      <= shimmer_in;
                        sh_full_reg <= shimmer_in;
                        zone_reg    <= energy_zone;
                        style_reg   <= style;
                        steps_reg   <= steps;
                        len_reg     <= (steps < MAXS) ? steps : MAXS;
                        case (energy_zone)
                            rmgr_pkg::ZONE_MINIMAL: gap_reg <= rmgr_pkg::GAP_MINIMAL;
                            rmgr_pkg::ZONE_GROOVE:  gap_reg <= gap_groove_reg;
                            rmgr_pkg::ZONE_BUILD:   gap_reg <= gap_build_reg;
                            default:                gap_reg <= gap_peak_reg;
                        endcase
                        case (energy_zone)
                            rmgr_pkg::ZONE_MINIMAL: run_reg <= rmgr_pkg::RUN_MINIMAL;
                            rmgr_pkg::ZONE_PEAK:    run_reg <= run_peak_reg;
                            default:                run_reg <= run_normal_reg;
                        endcase
                        pos_reg    <= '0;
                        i_reg      <= '0;
                        glen_reg   <= '0;
                        in_gap_reg <= 1'b0;
                        hit_reg    <= 1'b0;
                        any_a_reg  <= 1'b0;
                        gfix_reg   <= '0;
                        rfix_reg   <= '0;
                        best_reg   <= '0;
                        found_reg  <= 1'b0;
                        state_reg  <= S_GAP;
                    end
                end
                S_GAP:
                begin
                    // skip when gap limit not below steps, limit 0, or len 0
                    if (gap_reg >= steps_reg || gap_reg == 7'd0 || len_reg == 7'd0)
                        state_reg <= S_RUN_LONG;
                    else if (i_reg == len2)
                        state_reg <= S_GAP_ADD;
                    else
                    begin
                        if (!a_reg[0])
                        begin
                            if (!in_gap_reg)
                            begin
                                in_gap_reg <= 1'b1;
                                start_reg  <= pos_reg;
                                glen_reg   <= 8'd1;
                            end
                            else
                                glen_reg <= glen_inc;
                        end
                        else
                        begin
                            any_a_reg <= 1'b1;
                            if (in_gap_reg && glen_reg >= {1'b0, gap_reg} + 8'd1)
                            begin
                                if (!hit_reg || mid_pos < mid_reg)
                                    mid_reg <= mid_pos;
                                hit_reg <= 1'b1;
                            end
                            in_gap_reg <= 1'b0;
                            glen_reg   <= '0;
                        end
                        a_reg   <= rot1(a_reg, len_reg);
                        pos_reg <= pos_last ? 7'd0 : pos_reg + 7'd1;
                        // early break once a full-length gap is seen in pass two
                        if (i_reg >= {1'b0, len_reg} && !a_reg[0]
                            && (in_gap_reg ? glen_inc : 8'd1) >= {1'b0, len_reg})
                            i_reg <= len2;
                        else
                            i_reg <= i_reg + 8'd1;
                    end
                end
                S_GAP_ADD:
                begin
                    // mask is rotated by pos steps: bit k is step
                    // (pos+k) mod len; realign pos to zero by rotating first
                    if (pos_reg != 7'd0)
                    begin
                        a_reg   <= rot1(a_reg, len_reg);
                        pos_reg <= pos_last ? 7'd0 : pos_reg + 7'd1;
                    end
                    else if (!hit_reg || !any_a_reg)
                    begin
                        i_reg     <= '0;
                        glen_reg  <= '0;
                        state_reg <= S_RUN_LONG;
                    end
                    else
                    begin
                        a_reg[mid_reg[5:0]] <= 1'b1;
                        fix_reg    <= fix_inc;
                        gfix_reg   <= gfix_reg + GW'(1);
                        i_reg      <= '0;
                        glen_reg   <= '0;
                        in_gap_reg <= 1'b0;
                        hit_reg    <= 1'b0;
                        any_a_reg  <= 1'b0;
                        if (gfix_reg + GW'(1) >= GW'(GAP_FIX_LIMIT))
                            state_reg <= S_RUN_LONG;
                        else
                            state_reg <= S_GAP;
                    end
                end
                S_RUN_LONG:
                begin
                    // circular longest shimmer-only run, two laps
                    if (i_reg == len2)
                    begin
                        i_reg    <= '0;
                        glen_reg <= '0;
                        if (((best_reg < {1'b0, len_reg}) ? best_reg : {1'b0, len_reg})
                            > {1'b0, run_reg})
                            state_reg <= S_RUN_FIND;
                        else
                            state_reg <= S_BEAT;
                        best_reg <= '0;
                    end
                    else
                    begin
                        if (sonly)
                        begin
                            glen_reg <= glen_inc;
                            if (glen_inc > best_reg)
                                best_reg <= glen_inc;
                        end
                        else
                            glen_reg <= '0;
                        sh_reg  <= rot1(sh_reg, len_reg);
                        a_reg   <= rot1(a_reg, len_reg);
                        pos_reg <= pos_last ? 7'd0 : pos_reg + 7'd1;
                        if (sonly && glen_inc >= {1'b0, len_reg})
                            i_reg <= len2;
                        else
                            i_reg <= i_reg + 8'd1;
                    end
                end
                S_RUN_FIND:
                begin
                    if (pos_reg != 7'd0 && i_reg == 8'd0)
                    begin
                        // realign to step 0 before the linear pass
                        sh_reg  <= rot1(sh_reg, len_reg);
                        a_reg   <= rot1(a_reg, len_reg);
                        pos_reg <= pos_last ? 7'd0 : pos_reg + 7'd1;
                    end
                    else if (i_reg == {1'b0, len_reg} || found_reg)
                        state_reg <= S_RUN_ALIGN;
                    else
                    begin
                        if (sonly)
                        begin
                            glen_reg <= glen_inc;
                            if (glen_inc == {1'b0, run_reg} + 8'd1)
                            begin
                                found_reg <= 1'b1;
                                at_reg    <= pos_reg;
                            end
                        end
                        else
                            glen_reg <= '0;
                        if (!(sonly && glen_inc == {1'b0, run_reg} + 8'd1))
                        begin
                            sh_reg  <= rot1(sh_reg, len_reg);
                            a_reg   <= rot1(a_reg, len_reg);
                            pos_reg <= pos_last ? 7'd0 : pos_reg + 7'd1;
                        end
                        i_reg <= i_reg + 8'd1;
                    end
                end
                S_RUN_ALIGN:
                begin
                    if (found_reg)
                    begin
                        // the hit sits at bit 0 right now; drop it
                        sh_reg[0]   <= 1'b0;
                        sh_full_reg[at_reg[5:0]] <= 1'b0;
                        fix_reg     <= fix_inc;
                        rfix_reg    <= rfix_reg + RW'(1);
                        found_reg   <= 1'b0;
                        i_reg       <= '0;
                        glen_reg    <= '0;
                        if (rfix_reg + RW'(1) >= RW'(RUN_FIX_LIMIT))
                            state_reg <= S_BEAT;
                        else
                            state_reg <= S_RUN_LONG;
                    end
                    else
                        state_reg <= S_BEAT;
                end
                S_BEAT:
                begin
                    if (pos_reg != 7'd0)
                    begin
                        sh_reg  <= rot1(sh_reg, len_reg);
                        a_reg   <= rot1(a_reg, len_reg);
                        pos_reg <= pos_last ? 7'd0 : pos_reg + 7'd1;
                    end
                    else
                    begin
                        if (zone_reg != rmgr_pkg::ZONE_MINIMAL
                            && style_reg == rmgr_pkg::STYLE_TECHNO
                            && steps_reg >= rmgr_pkg::BACKBEAT_MIN_STEPS
                            && (sh_full_reg & backbeat_reg
                                & ((steps_reg >= 7'd64) ? {W{1'b1}}
                                   : ({W{1'b1}} >> (7'd64 - steps_reg)))) == '0
                            && sh_full_reg != '0)
                        begin
                            sh_reg[rmgr_pkg::BACKBEAT_STEP] <= 1'b1;
                            fix_reg <= fix_inc;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // hand over once the output register is free
                    if (!out_valid || !out_stall)
                    begin
                        anchor_out  <= a_reg;
                        shimmer_out <= sh_reg;
                        fix_count   <= fix_reg;
                        out_valid   <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
